// ===== rtl/fdnp_pkg.sv =====
// Types, character codes and the digit-to-ASCII helper for the format printer.
// No dependencies; compiled first.
package fdnp_pkg;

	// Digit scratch depth: enough for a 32-bit word in octal
	localparam int DIGIT_SLOTS = 11;
	// Index / fill-count width for the digit scratch (0..DIGIT_SLOTS)
	localparam int DIG_IDX_W = 4;

	typedef logic [7:0] char_t;

	// ASCII codes used by the directive decoder and hex_char
	localparam char_t CH_PERCENT = 8'h25;
	localparam char_t CH_MINUS   = 8'h2D;
	localparam char_t CH_ZERO    = 8'h30;
	localparam char_t CH_LOWER_A = 8'h61;
	localparam char_t CH_C       = 8'h63;
	localparam char_t CH_D       = 8'h64;
	localparam char_t CH_I       = 8'h69;
	localparam char_t CH_O       = 8'h6F;
	localparam char_t CH_P       = 8'h70;
	localparam char_t CH_U       = 8'h75;
	localparam char_t CH_X       = 8'h78;

	// Sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_PRE,
		S_MUL,
		S_REM,
		S_DIG
	} fdnp_state_t;

	// Number base of the current directive
	typedef enum logic [1:0] {
		RADIX_DEC,
		RADIX_OCT,
		RADIX_HEX
	} base_t;

	// Digit value 0..15 to lowercase ASCII
	function automatic char_t hex_char(input logic [3:0] d);
		if (d < 4'd10) begin
			return CH_ZERO + {4'd0, d};
		end
		return CH_LOWER_A + {4'd0, d - 4'd10};
	endfunction

endpackage

// ===== rtl/fdnp_if.sv =====
// Valid/ready channel interfaces: format bytes in, characters out.
// No dependencies.
interface fdnp_fmt_if;
	logic        valid;
	logic        ready;
	logic [7:0]  fmt_char;
	logic [31:0] arg_value;

	modport source (output valid, output fmt_char, output arg_value, input ready);
	modport sink   (input valid, input fmt_char, input arg_value, output ready);
endinterface

interface fdnp_text_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_char;
	logic        last;
	logic [15:0] char_count;

	modport source (output valid, output out_char, output last, output char_count, input ready);
	modport sink   (input valid, input out_char, input last, input char_count, output ready);
endinterface

// ===== rtl/fdnp_digit_unit.sv =====
// Shared quotient/remainder unit: one base-10/8/16 digit step, quotient registered.
// Depends on fdnp_pkg (base_t).
module fdnp_digit_unit
	import fdnp_pkg::*;
#(
	parameter int ARG_BITS = 32
) (
	input  logic                clk,
	input  logic [ARG_BITS-1:0] mag,
	input  base_t               base,
	output logic [ARG_BITS-1:0] quo_q,
	output logic [3:0]          digit
);

	// Reciprocal of ten, exact for every ARG_BITS-bit dividend
	localparam int RECIP_SHIFT = ARG_BITS + 4;
	localparam logic [ARG_BITS:0] RECIP10 =
		(ARG_BITS+1)'(((64'd1 << RECIP_SHIFT) + 64'd9) / 64'd10);

	logic [2*ARG_BITS:0] prod;
	logic [ARG_BITS-1:0] quo_d;
	logic [3:0]          qb_low;

	// Quotient: multiply by reciprocal for decimal, plain shift otherwise
	assign prod = {{(ARG_BITS+1){1'b0}}, mag} * {{ARG_BITS{1'b0}}, RECIP10};

	always_comb begin
		case (base)
			RADIX_DEC: quo_d = {3'b000, prod[2*ARG_BITS:RECIP_SHIFT]};
			RADIX_OCT: quo_d = {3'b000, mag[ARG_BITS-1:3]};
			RADIX_HEX: quo_d = {4'b0000, mag[ARG_BITS-1:4]};
			default:   quo_d = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		quo_q <= quo_d;
	end

	// Remainder = mag - quo*base; only the low nibble matters
	always_comb begin
		case (base)
			RADIX_DEC: qb_low = {quo_q[0], 3'b000} + {quo_q[2:0], 1'b0};
			RADIX_OCT: qb_low = {quo_q[0], 3'b000};
			RADIX_HEX: qb_low = 4'd0;
			default:   qb_low = 4'd0;
		endcase
	end

	assign digit = mag[3:0] - qb_low;

endmodule

// ===== rtl/format_directive_number_printer.sv =====
// Printf-style integer formatter: format bytes in, ASCII characters out.
// Depends on fdnp_pkg, fdnp_if (fdnp_fmt_if, fdnp_text_if) and fdnp_digit_unit.
//
// Usage:
//   fmt  : one format byte plus an argument word per item (valid/ready).
//   text : one character per item, with last set on the final character caused
//          by an input item, and a saturating running character count.
//   Ordinary bytes are echoed; '%' arms a flag and the next byte picks the
//   directive (d i u o x p c %); unknown directives print '%' and the byte.
// Timing:
//   fmt.ready is high only while the sequencer is idle. An echoed byte passes
//   through S_PRE into the output register once the slot is free; a lone '%'
//   only arms the flag. A number emits its prefix characters ('-', "0x"), then
//   runs each digit through the shared quotient unit in S_MUL (multiply) and
//   S_REM (remainder), then emits the digits, most significant first.
//   The next item is taken once the sequencer is back in S_IDLE.
// Reset: arst_n clears the sequencer, the '%' flag and the character count.
// Stall: a full output register holding its character stops emission; the
//   next item may still be accepted while the last character waits.
module format_directive_number_printer
	import fdnp_pkg::*;
#(
	parameter int ARG_BITS = 32
) (
	input logic        clk,
	input logic        arst_n,
	fdnp_fmt_if.sink   fmt,
	fdnp_text_if.source text
);

	fdnp_state_t state_q, state_d;

	logic                 after_pct_q;
	logic [15:0]          total_q;
	logic [15:0]          total_inc;
	char_t                pre0_q, pre1_q;
	logic [1:0]           pre_left_q;
	logic                 num_q;
	logic [ARG_BITS-1:0]  mag_q;
	base_t                base_q;
	logic [3:0]           digits_q [DIGIT_SLOTS];
	logic [DIG_IDX_W-1:0] ndig_q;

	logic                 out_valid_q;
	char_t                out_char_q;
	logic                 out_last_q;
	logic [15:0]          out_count_q;

	// Decoder outputs
	logic [ARG_BITS-1:0]  arg, arg_neg;
	char_t                dec_pre0, dec_pre1;
	logic [1:0]           dec_left;
	logic                 dec_num;
	logic [ARG_BITS-1:0]  dec_mag;
	base_t                dec_base;
	logic                 dec_arm;

	// Sequencer outputs
	logic                 accept;
	logic                 slot_free;
	logic                 emit;
	char_t                emit_char;
	logic                 emit_last;

	// Shared digit unit
	logic [ARG_BITS-1:0]  quo_q;
	logic [3:0]           digit;

	fdnp_digit_unit #(
		.ARG_BITS(ARG_BITS)
	) u_digit (
		.clk   (clk),
		.mag   (mag_q),
		.base  (base_q),
		.quo_q (quo_q),
		.digit (digit)
	);

	assign accept    = fmt.valid && fmt.ready;
	assign slot_free = !out_valid_q || text.ready;
	assign total_inc = (total_q == 16'hFFFF) ? total_q : total_q + 16'd1;

	// Directive decode of the incoming item
	assign arg     = fmt.arg_value[ARG_BITS-1:0];
	assign arg_neg = ~arg + {{(ARG_BITS-1){1'b0}}, 1'b1};

	always_comb begin
		dec_pre0 = fmt.fmt_char;
		dec_pre1 = fmt.fmt_char;
		dec_left = 2'd1;
		dec_num  = 1'b0;
		dec_mag  = arg;
		dec_base = RADIX_DEC;
		dec_arm  = 1'b0;
		if (!after_pct_q) begin
			if (fmt.fmt_char == CH_PERCENT) begin
				dec_arm  = 1'b1;
				dec_left = 2'd0;
			end
		end else begin
			case (fmt.fmt_char)
				CH_D, CH_I: begin
					dec_num = 1'b1;
					if (arg[ARG_BITS-1]) begin
						dec_pre0 = CH_MINUS;
						dec_mag  = arg_neg;
					end else begin
						dec_left = 2'd0;
					end
				end
				CH_U: begin
					dec_num  = 1'b1;
					dec_left = 2'd0;
				end
				CH_O: begin
					dec_num  = 1'b1;
					dec_left = 2'd0;
					dec_base = RADIX_OCT;
				end
				CH_X: begin
					dec_num  = 1'b1;
					dec_left = 2'd0;
					dec_base = RADIX_HEX;
				end
				CH_P: begin
					dec_num  = 1'b1;
					dec_pre0 = CH_ZERO;
					dec_pre1 = CH_X;
					dec_left = 2'd2;
					dec_base = RADIX_HEX;
				end
				CH_C: begin
					dec_pre0 = fmt.arg_value[7:0];
				end
				CH_PERCENT: begin
					dec_pre0 = CH_PERCENT;
				end
				default: begin
					dec_pre0 = CH_PERCENT;
					dec_left = 2'd2;
				end
			endcase
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (dec_left != 2'd0) begin
						state_d = S_PRE;
					end else if (dec_num) begin
						state_d = S_MUL;
					end
				end
			end
			S_PRE: begin
				if (slot_free && pre_left_q == 2'd1) begin
					state_d = num_q ? S_MUL : S_IDLE;
				end
			end
			S_MUL: state_d = S_REM;
			S_REM: state_d = (quo_q == '0) ? S_DIG : S_MUL;
			S_DIG: begin
				if (slot_free && ndig_q == DIG_IDX_W'(1)) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		fmt.ready = 1'b0;
		emit      = 1'b0;
		emit_char = pre0_q;
		emit_last = 1'b0;
		case (state_q)
			S_IDLE: fmt.ready = 1'b1;
			S_PRE: begin
				emit      = slot_free;
				emit_last = (pre_left_q == 2'd1) && !num_q;
			end
			S_DIG: begin
				emit      = slot_free;
				emit_char = hex_char(digits_q[ndig_q - DIG_IDX_W'(1)]);
				emit_last = (ndig_q == DIG_IDX_W'(1));
			end
			default: ;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			after_pct_q <= 1'b0;
			total_q     <= '0;
			pre_left_q  <= '0;
			num_q       <= 1'b0;
			ndig_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				after_pct_q <= dec_arm;
				pre_left_q  <= dec_left;
				num_q       <= dec_num;
				ndig_q      <= '0;
			end
			if (state_q == S_PRE && emit) begin
				pre_left_q <= pre_left_q - 2'd1;
			end
			if (state_q == S_REM) begin
				ndig_q <= ndig_q + DIG_IDX_W'(1);
			end
			if (state_q == S_DIG && emit) begin
				ndig_q <= ndig_q - DIG_IDX_W'(1);
			end
			if (emit) begin
				total_q     <= total_inc;
				out_valid_q <= 1'b1;
			end else if (text.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			pre0_q <= dec_pre0;
			pre1_q <= dec_pre1;
			mag_q  <= dec_mag;
			base_q <= dec_base;
		end
		if (state_q == S_PRE && emit) begin
			pre0_q <= pre1_q;
		end
		// Store one digit, carry the quotient on
		if (state_q == S_REM) begin
			digits_q[ndig_q] <= digit;
			mag_q            <= quo_q;
		end
		if (emit) begin
			out_char_q  <= emit_char;
			out_last_q  <= emit_last;
			out_count_q <= total_inc;
		end
	end

	assign text.valid      = out_valid_q;
	assign text.out_char   = out_char_q;
	assign text.last       = out_last_q;
	assign text.char_count = out_count_q;

	// Checks
	a_dig_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIG |-> ndig_q != '0)
		else $error("digit emission with empty digit scratch");

	a_count_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> total_q >= $past(total_q))
		else $error("character count went backwards");

	a_count_out: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> text.valid && text.char_count == total_q)
		else $error("output count does not match running total");

endmodule
